@@ rtl/dnsfa_pkg.sv @@
package dnsfa_pkg;

	localparam int MAX_PACKET_BYTES = 512;
	localparam int POS_W = $clog2(MAX_PACKET_BYTES);
	// last byte position that still leaves room for the 16-byte answer
	localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_PACKET_BYTES - 17);

	localparam int CMD_DEPTH = 4;
	localparam int CMD_PTR_W = $clog2(CMD_DEPTH);

	localparam int PADDR_W = 3;
	localparam logic REG_TARGET_ADDRESS = 1'b0;

	localparam logic [3:0] ANS_LAST_IDX = 4'd15;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       packet_end;
	} query_t;

	typedef struct packed {
		logic [7:0] reply_byte;
		logic       reply_last;
		logic       reply_drop;
	} reply_t;

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_LEN,
		PH_BODY,
		PH_TAIL,
		PH_SKIP
	} phase_t;

	typedef enum logic [1:0] {
		CMD_BYTE,
		CMD_ANSWER,
		CMD_DROP
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t  kind;
		logic [7:0] data;
	} cmd_t;

	typedef struct packed {
		logic push;
		cmd_t cmd;
	} cmd_push_t;

	function automatic logic [7:0] hdr_byte(input logic [3:0] idx);
		logic [7:0] b;
		unique case (idx)
			4'd2: b = 8'h81;
			4'd3: b = 8'h80;
			4'd5: b = 8'h01;
			4'd7: b = 8'h01;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

	// answer record: pointer to offset 12, type A, class IN, TTL 60, rdlength 4, address
	function automatic logic [7:0] ans_byte(input logic [3:0] idx, input logic [31:0] addr);
		logic [7:0] b;
		unique case (idx)
			4'd0:  b = 8'hC0;
			4'd1:  b = 8'h0C;
			4'd3:  b = 8'h01;
			4'd5:  b = 8'h01;
			4'd9:  b = 8'h3C;
			4'd11: b = 8'h04;
			4'd12: b = addr[7:0];
			4'd13: b = addr[15:8];
			4'd14: b = addr[23:16];
			4'd15: b = addr[31:24];
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

@@ rtl/dns_query_to_fixed_a_reply.sv @@
// channel  | handshake          | payload
// query    | push / full        | query_t: data_byte, packet_end
// reply    | pop / empty        | reply_t: reply_byte, reply_last, reply_drop
// config   | APB psel/penable   | target_address at byte address 0
//
// One query byte is taken per cycle while full is low. An accepted byte is written to the
// command queue, then registered in the back end's output register until it is popped.
// The byte that completes QCLASS yields 17 items, emitted one per cycle by the back end
// unless pop stalls; the 4-entry command queue absorbs input meanwhile and push is refused only when it fills.
// Reset (arst_n low) clears parser, queue and output state; target_address -> 0.
module dns_query_to_fixed_a_reply import dnsfa_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  query_t             query,
	output logic               empty,
	input  logic               pop,
	output reply_t             reply,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	logic        target_sel;
	logic [31:0] target_address_q;
	cmd_push_t   front_cmd;
	cmd_t        q_cmd;
	logic        q_empty, q_pop, res_valid;

	assign pready     = 1'b1;
	assign target_sel = (paddr[2] == REG_TARGET_ADDRESS);
	assign prdata     = target_sel ? target_address_q : 32'h0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			target_address_q <= '0;
		else if (psel && penable && pwrite && pready && target_sel)
			target_address_q <= pwdata;
	end

	dnsfa_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (push && !full),
		.query   (query),
		.cmd_out (front_cmd)
	);

	dnsfa_cmd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (front_cmd),
		.full     (full),
		.rd_pop   (q_pop),
		.rd_cmd   (q_cmd),
		.rd_empty (q_empty)
	);

	dnsfa_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_cmd          (q_cmd),
		.q_empty        (q_empty),
		.q_pop          (q_pop),
		.target_address (target_address_q),
		.res            (reply),
		.res_valid      (res_valid),
		.res_pop        (pop && res_valid)
	);

	assign empty = !res_valid;

endmodule

@@ rtl/dnsfa_front.sv @@
module dnsfa_front import dnsfa_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      accept,
	input  query_t    query,
	output cmd_push_t cmd_out
);

	phase_t           phase_q, phase_n;
	logic [POS_W-1:0] pos_q, pos_n;
	logic [5:0]       label_q, label_n;
	logic [2:0]       tail_q, tail_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			pos_q   <= '0;
			label_q <= '0;
			tail_q  <= '0;
		end else begin
			phase_q <= phase_n;
			pos_q   <= pos_n;
			label_q <= label_n;
			tail_q  <= tail_n;
		end
	end

	always_comb begin
		logic       done;
		logic [5:0] label_dec;
		logic [2:0] tail_dec;
		phase_n = phase_q;
		pos_n   = pos_q;
		label_n = label_q;
		tail_n  = tail_q;
		cmd_out.push     = 1'b0;
		cmd_out.cmd.kind = CMD_BYTE;
		cmd_out.cmd.data = query.data_byte;
		done      = 1'b0;
		label_dec = label_q - 6'(label_q != '0);
		tail_dec  = tail_q - 3'(tail_q != '0);
		if (accept) begin
			if (phase_q == PH_SKIP) begin
				if (query.packet_end) begin
					phase_n = PH_HEADER;
					pos_n   = '0;
					label_n = '0;
					tail_n  = '0;
				end
			end else if (pos_q > POS_LIMIT) begin
				cmd_out.push     = 1'b1;
				cmd_out.cmd.kind = CMD_DROP;
				cmd_out.cmd.data = '0;
				phase_n = query.packet_end ? PH_HEADER : PH_SKIP;
				pos_n   = '0;
				label_n = '0;
				tail_n  = '0;
			end else begin
				cmd_out.push = 1'b1;
				unique case (phase_q)
					PH_HEADER: begin
						if (pos_q >= POS_W'(2) && pos_q < POS_W'(12))
							cmd_out.cmd.data = hdr_byte(pos_q[3:0]);
						if (pos_q >= POS_W'(11))
							phase_n = PH_LEN;
					end
					PH_LEN: begin
						// zero byte or a compression/extended tag ends the name
						if (query.data_byte == 8'h00 || query.data_byte[7:6] != 2'b00) begin
							phase_n = PH_TAIL;
							tail_n  = 3'd4;
						end else begin
							phase_n = PH_BODY;
							label_n = query.data_byte[5:0];
						end
					end
					PH_BODY: begin
						label_n = label_dec;
						if (label_dec == '0)
							phase_n = PH_LEN;
					end
					PH_TAIL: begin
						tail_n = tail_dec;
						if (tail_dec == '0)
							done = 1'b1;
					end
					PH_SKIP: ;
				endcase
				if (done) begin
					cmd_out.cmd.kind = CMD_ANSWER;
					phase_n = query.packet_end ? PH_HEADER : PH_SKIP;
					pos_n   = '0;
					label_n = '0;
					tail_n  = '0;
				end else if (query.packet_end) begin
					cmd_out.cmd.kind = CMD_DROP;
					cmd_out.cmd.data = '0;
					phase_n = PH_HEADER;
					pos_n   = '0;
					label_n = '0;
					tail_n  = '0;
				end else begin
					pos_n = pos_q + POS_W'(1);
				end
			end
		end
	end

endmodule

@@ rtl/dnsfa_cmd_queue.sv @@
module dnsfa_cmd_queue import dnsfa_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cmd_push_t wr,
	output logic      full,
	input  logic      rd_pop,
	output cmd_t      rd_cmd,
	output logic      rd_empty
);

	cmd_t               mem [CMD_DEPTH];
	logic [CMD_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CMD_PTR_W:0]   count_q;

	assign full     = (count_q == (CMD_PTR_W+1)'(CMD_DEPTH));
	assign rd_empty = (count_q == '0);
	assign rd_cmd   = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr.push)
			mem[wr_ptr_q] <= wr.cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr.push)
				wr_ptr_q <= wr_ptr_q + CMD_PTR_W'(1);
			if (rd_pop)
				rd_ptr_q <= rd_ptr_q + CMD_PTR_W'(1);
			count_q <= count_q + (CMD_PTR_W+1)'(wr.push) - (CMD_PTR_W+1)'(rd_pop);
		end
	end

endmodule

@@ rtl/dnsfa_back.sv @@
module dnsfa_back import dnsfa_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        q_cmd,
	input  logic        q_empty,
	output logic        q_pop,
	input  logic [31:0] target_address,
	output reply_t      res,
	output logic        res_valid,
	input  logic        res_pop
);

	reply_t     res_q, res_n;
	logic       vld_q, vld_n;
	logic       burst_q, burst_n;
	logic [3:0] idx_q, idx_n;
	logic       can_load, load;

	assign can_load  = !vld_q || res_pop;
	assign res       = res_q;
	assign res_valid = vld_q;

	always_ff @(posedge clk) begin
		if (load)
			res_q <= res_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= 1'b0;
			burst_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			vld_q   <= vld_n;
			burst_q <= burst_n;
			idx_q   <= idx_n;
		end
	end

	always_comb begin
		q_pop   = 1'b0;
		load    = 1'b0;
		burst_n = burst_q;
		idx_n   = idx_q;
		res_n   = '{reply_byte: q_cmd.data, reply_last: 1'b0, reply_drop: 1'b0};
		if (can_load) begin
			if (burst_q) begin
				load  = 1'b1;
				res_n = '{reply_byte: ans_byte(idx_q, target_address),
				          reply_last: (idx_q == ANS_LAST_IDX), reply_drop: 1'b0};
				idx_n = idx_q + 4'd1;
				if (idx_q == ANS_LAST_IDX)
					burst_n = 1'b0;
			end else if (!q_empty) begin
				q_pop = 1'b1;
				load  = 1'b1;
				unique case (q_cmd.kind)
					CMD_BYTE: ;
					CMD_ANSWER: begin
						burst_n = 1'b1;
						idx_n   = '0;
					end
					CMD_DROP: res_n = '{reply_byte: 8'h00, reply_last: 1'b1, reply_drop: 1'b1};
					default: ;
				endcase
			end
		end
		vld_n = load ? 1'b1 : (can_load ? 1'b0 : vld_q);
	end

	// the answer burst owns the output; queued items wait until it ends
	a_no_pop_in_burst: assert property (@(posedge clk) disable iff (!arst_n)
		burst_q |-> !q_pop)
		else $error("queue popped during answer burst");

	a_drop_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q && res_q.reply_drop) |-> (res_q.reply_last && res_q.reply_byte == 8'h00))
		else $error("drop result malformed");

	a_burst_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(burst_q && can_load && idx_q == ANS_LAST_IDX) |=> (!burst_q && vld_q && res_q.reply_last))
		else $error("answer burst did not end with last");

	a_answer_starts_burst: assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop && q_cmd.kind == CMD_ANSWER) |=> (burst_q && idx_q == 4'd0 && !res_q.reply_last))
		else $error("answer item did not start burst");

endmodule

@@ tb/sv/tb_dns_query_to_fixed_a_reply.sv @@
`timescale 1ns / 1ps

module tb_dns_query_to_fixed_a_reply import dnsfa_pkg::*;;

	localparam int IDLE_LIMIT = 3000;
	localparam int SETTLE_CYCLES = 8;
	localparam logic [PADDR_W-1:0] ADDR_TARGET = PADDR_W'(4 * REG_TARGET_ADDRESS);
	// no register behind this address, writes must be ignored
	localparam logic [PADDR_W-1:0] ADDR_NO_REG = PADDR_W'(4);

	localparam logic [0:11][7:0] HDR_FIXED = {8'h00, 8'h00, 8'h81, 8'h80, 8'h00, 8'h01,
		8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00};
	localparam logic [0:11][7:0] ANSWER_FIXED = {8'hC0, 8'h0C, 8'h00, 8'h01, 8'h00, 8'h01,
		8'h00, 8'h00, 8'h00, 8'h3C, 8'h00, 8'h04};

	logic               clk;
	logic               arst_n = 1'b0;
	logic               push = 1'b0;
	logic               full;
	query_t             query = '0;
	logic               empty;
	logic               pop = 1'b0;
	reply_t             reply;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;

	dns_query_to_fixed_a_reply dut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.query  (query),
		.empty  (empty),
		.pop    (pop),
		.reply  (reply),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// responder model state
	logic [31:0] target_addr = '0;
	int          frame_pos = 0;
	phase_t      parse_state = PH_HEADER;
	logic [7:0]  label_left = '0;
	logic [2:0]  tail_left = '0;

	query_t      query_backlog[$];
	reply_t      replies_due[$];
	logic [7:0]  pkt_bytes[$];
	int          stim_items = 0;
	int          mismatches = 0;
	int          idle_cycles = 0;

	int burst_left = 0;
	int gap_left = 0;
	int stall_mode = 0;
	int stall_run = 0;

	task automatic report(input string msg);
		mismatches++;
		if (mismatches <= 100)
			$display("mismatch at %0t: %s", $time, msg);
	endtask

	task automatic restart_frame(input phase_t next_state);
		frame_pos = 0;
		label_left = '0;
		tail_left = '0;
		parse_state = next_state;
	endtask

	task automatic drop_frame(input logic end_seen);
		replies_due.push_back(reply_t'{8'h00, 1'b1, 1'b1});
		restart_frame(end_seen ? PH_HEADER : PH_SKIP);
	endtask

	task automatic predict_reply(input query_t q);
		logic [7:0] b;
		logic       qclass_done;
		b = q.data_byte;
		qclass_done = 1'b0;
		if (parse_state == PH_SKIP) begin
			if (q.packet_end)
				restart_frame(PH_HEADER);
			return;
		end
		// no room left for the answer record
		if (frame_pos + 17 > MAX_PACKET_BYTES) begin
			drop_frame(q.packet_end);
			return;
		end
		case (parse_state)
			PH_HEADER: begin
				if (frame_pos >= 2 && frame_pos < 12)
					b = HDR_FIXED[frame_pos];
				if (frame_pos >= 11)
					parse_state = PH_LEN;
			end
			PH_LEN: begin
				if (q.data_byte == 8'h00 || q.data_byte[7:6] != 2'b00) begin
					parse_state = PH_TAIL;
					tail_left = 3'd4;
				end else begin
					parse_state = PH_BODY;
					label_left = q.data_byte;
				end
			end
			PH_BODY: begin
				if (label_left != 0)
					label_left--;
				if (label_left == 0)
					parse_state = PH_LEN;
			end
			default: begin
				if (tail_left != 0)
					tail_left--;
				if (tail_left == 0)
					qclass_done = 1'b1;
			end
		endcase
		if (qclass_done) begin
			replies_due.push_back(reply_t'{b, 1'b0, 1'b0});
			for (int k = 0; k < 12; k++)
				replies_due.push_back(reply_t'{ANSWER_FIXED[k], 1'b0, 1'b0});
			for (int k = 0; k < 4; k++)
				replies_due.push_back(reply_t'{target_addr[8*k +: 8], k == 3, 1'b0});
			restart_frame(q.packet_end ? PH_HEADER : PH_SKIP);
			return;
		end
		if (q.packet_end) begin
			drop_frame(1'b1);
			return;
		end
		replies_due.push_back(reply_t'{b, 1'b0, 1'b0});
		frame_pos++;
	endtask

	task automatic check_reply(input reply_t got);
		reply_t want;
		if (replies_due.size() == 0) begin
			report($sformatf("reply item with nothing pending: byte %h last %b drop %b",
				got.reply_byte, got.reply_last, got.reply_drop));
			return;
		end
		want = replies_due.pop_front();
		if (got.reply_byte !== want.reply_byte)
			report($sformatf("reply_byte %h, want %h", got.reply_byte, want.reply_byte));
		if (got.reply_last !== want.reply_last)
			report($sformatf("reply_last %b, want %b", got.reply_last, want.reply_last));
		if (got.reply_drop !== want.reply_drop)
			report($sformatf("reply_drop %b, want %b", got.reply_drop, want.reply_drop));
	endtask

	// sender: bursts of random length, random gaps in between
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push <= 1'b0;
			query <= '0;
			burst_left = 0;
			gap_left = 0;
		end else begin
			if (push && !full)
				predict_reply(query);
			if (!push || !full) begin
				if (gap_left != 0 || query_backlog.size() == 0) begin
					push <= 1'b0;
					if (gap_left != 0)
						gap_left--;
				end else begin
					push <= 1'b1;
					query <= query_backlog.pop_front();
					if (burst_left == 0)
						burst_left = $urandom_range(1, 48);
					burst_left--;
					if (burst_left == 0)
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
				end
			end
		end
	end

	// receiver: stall pattern switches between free running, random and long stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 1'b0;
			stall_mode = 0;
			stall_run = 0;
		end else begin
			if (pop && !empty)
				check_reply(reply);
			if (stall_run == 0) begin
				stall_mode = $urandom_range(0, 3);
				stall_run = $urandom_range(4, 60);
			end
			stall_run--;
			case (stall_mode)
				0: pop <= 1'b1;
				1: pop <= 1'($urandom_range(0, 1));
				2: pop <= ($urandom_range(0, 3) == 0);
				default: pop <= 1'b0;
			endcase
		end
	end

	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || psel)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
			$display("** dns_query_to_fixed_a_reply: FAILED **");
			$finish;
		end
	end

	// write a register, then read the target address back
	task automatic program_target(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (addr == ADDR_TARGET)
			target_addr = data;
		pwrite <= 1'b0;
		penable <= 1'b0;
		paddr <= ADDR_TARGET;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== target_addr)
			report($sformatf("target_address reads %h, want %h", prdata, target_addr));
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic settle();
		while (query_backlog.size() != 0 || push)
			@(posedge clk);
		while (replies_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic send_packet(input int n);
		for (int i = 0; i < n; i++)
			query_backlog.push_back(query_t'{pkt_bytes[i], i == n - 1});
		stim_items += n;
	endtask

	task automatic start_query();
		pkt_bytes.delete();
		repeat (12) pkt_bytes.push_back(8'($urandom));
	endtask

	task automatic add_label(input int len);
		pkt_bytes.push_back(8'(len));
		repeat (len) pkt_bytes.push_back(8'($urandom));
	endtask

	// name terminator: root, or a length byte with one or both top bits set
	task automatic finish_query(input int trailing);
		logic [7:0] low6;
		low6 = 8'($urandom_range(0, 63));
		case ($urandom_range(0, 3))
			0: pkt_bytes.push_back(8'h00);
			1: pkt_bytes.push_back(8'h40 | low6);
			2: pkt_bytes.push_back(8'h80 | low6);
			default: pkt_bytes.push_back(8'hC0 | low6);
		endcase
		repeat (4 + trailing) pkt_bytes.push_back(8'($urandom));
	endtask

	task automatic random_packet();
		int kind;
		int trailing;
		int n;
		kind = $urandom_range(0, 9);
		if (kind < 2) begin
			pkt_bytes.delete();
			n = $urandom_range(1, 40);
			repeat (n) pkt_bytes.push_back(8'($urandom));
			send_packet(n);
		end else begin
			start_query();
			repeat ($urandom_range(0, 3))
				add_label(($urandom_range(0, 9) == 0) ? 63 : $urandom_range(1, 8));
			trailing = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 4);
			finish_query(trailing);
			if (kind < 4) begin
				// frame ends before the last QCLASS byte
				send_packet($urandom_range(1, pkt_bytes.size() - 1 - trailing));
			end else begin
				send_packet(pkt_bytes.size());
				stim_items -= trailing;
			end
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// one-byte frame, a frame cut inside the header, then a root-name query
		pkt_bytes = '{8'hFF};
		send_packet(1);
		pkt_bytes = '{8'h00, 8'hFF, 8'h00};
		send_packet(3);
		pkt_bytes = '{8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00,
			8'hFF, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'hA5};
		send_packet(18);
		settle();

		program_target(ADDR_TARGET, 32'hFFFF_FFFF);
		while (stim_items < 120)
			random_packet();
		settle();

		program_target(ADDR_NO_REG, 32'($urandom));
		program_target(ADDR_TARGET, 32'($urandom));
		// question ends at the last position that fits, then twice one byte beyond it
		for (int k = 0; k < 3; k++) begin
			start_query();
			repeat (7) add_label(63);
			add_label((k == 0) ? 30 : 31);
			finish_query((k == 2) ? 3 : 0);
			send_packet(pkt_bytes.size());
		end
		stim_items = 120;
		while (stim_items < 220)
			random_packet();
		settle();

		program_target(ADDR_TARGET, 32'h0000_0000);
		while (stim_items < 280)
			random_packet();
		settle();

		program_target(ADDR_TARGET, 32'($urandom));
		while (stim_items < 340)
			random_packet();
		settle();

		if (mismatches == 0)
			$display("** dns_query_to_fixed_a_reply: PASSED **");
		else
			$display("** dns_query_to_fixed_a_reply: FAILED **");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/dnsfa_pkg.sv
rtl/dnsfa_front.sv
rtl/dnsfa_cmd_queue.sv
rtl/dnsfa_back.sv
rtl/dns_query_to_fixed_a_reply.sv
tb/sv/tb_dns_query_to_fixed_a_reply.sv
